@@ hdl/lpc_pkg.sv @@
// lpc_pkg: shared types and constants for the level pump controller
`timescale 1ns / 1ps

package lpc_pkg;

    localparam int LEVEL_W   = 7;
    localparam int COUNT_W   = 8;
    localparam int TIME_W    = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 7'd100;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

    typedef enum logic [1:0] {
        MODE_OFF     = 2'd0,
        MODE_RUN     = 2'd1,
        MODE_SENSOR  = 2'd2,
        MODE_TIMEOUT = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_THR  = 3'd0,
        CFG_STOP_THR   = 3'd1,
        CFG_CHANGE_CNF = 3'd2,
        CFG_RECOV_CNF  = 3'd3,
        CFG_FAIL_LIMIT = 3'd4,
        CFG_MAX_FILL   = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level_pct;
        logic               reading_valid;
        logic [TIME_W-1:0]  now_ms;
    } lpc_in_t;

    typedef struct packed {
        logic       relay_on;
        logic [1:0] mode;
    } lpc_out_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] start_threshold_pct;
        logic [LEVEL_W-1:0] stop_threshold_pct;
        logic [COUNT_W-1:0] change_confirmations;
        logic [COUNT_W-1:0] recovery_confirmations;
        logic [COUNT_W-1:0] failure_limit;
        logic [TIME_W-1:0]  max_fill_ms;
    } lpc_cfg_t;

    // status from the mode controller back to the top level and filter
    typedef struct packed {
        mode_t mode;
        mode_t mode_next;
        logic  window_clear;
    } lpc_ctrl_t;

endpackage

@@ hdl/lpc_cfg_regs.sv @@
// lpc_cfg_regs: configuration register file
`timescale 1ns / 1ps

module lpc_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               wr_en,
    input  logic [lpc_pkg::CFG_IDX_W-1:0]      wr_index,
    input  logic [lpc_pkg::CFG_DATA_W-1:0]     wr_data,
    output lpc_pkg::lpc_cfg_t                  cfg
);

    lpc_pkg::lpc_cfg_t cfg_reg;
    lpc_pkg::lpc_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                lpc_pkg::CFG_START_THR:
                    cfg_next.start_threshold_pct = wr_data[lpc_pkg::LEVEL_W-1:0];
                lpc_pkg::CFG_STOP_THR:
                    cfg_next.stop_threshold_pct = wr_data[lpc_pkg::LEVEL_W-1:0];
                lpc_pkg::CFG_CHANGE_CNF:
                    cfg_next.change_confirmations = wr_data[lpc_pkg::COUNT_W-1:0];
                lpc_pkg::CFG_RECOV_CNF:
                    cfg_next.recovery_confirmations = wr_data[lpc_pkg::COUNT_W-1:0];
                lpc_pkg::CFG_FAIL_LIMIT:
                    cfg_next.failure_limit = wr_data[lpc_pkg::COUNT_W-1:0];
                lpc_pkg::CFG_MAX_FILL:
                    cfg_next.max_fill_ms = wr_data[lpc_pkg::TIME_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_threshold_pct    <= 7'd20;
            cfg_reg.stop_threshold_pct     <= 7'd90;
            cfg_reg.change_confirmations   <= 8'd3;
            cfg_reg.recovery_confirmations <= 8'd5;
            cfg_reg.failure_limit          <= 8'd5;
            cfg_reg.max_fill_ms            <= 32'd600000;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ hdl/lpc_median.sv @@
// lpc_median: three-sample median window with first-fill behavior
`timescale 1ns / 1ps

module lpc_median (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  logic                          clear,
    input  logic [lpc_pkg::LEVEL_W-1:0]   level_pct,
    output logic [lpc_pkg::LEVEL_W-1:0]   median
);

    logic [lpc_pkg::LEVEL_W-1:0] win_reg [3];
    logic [lpc_pkg::LEVEL_W-1:0] win_next [3];
    logic                        filled_reg;
    logic                        filled_next;
    logic [lpc_pkg::LEVEL_W-1:0] sample;
    logic [lpc_pkg::LEVEL_W-1:0] lo;
    logic [lpc_pkg::LEVEL_W-1:0] hi;
    logic [lpc_pkg::LEVEL_W-1:0] hi_c;

    assign sample = (level_pct > lpc_pkg::LEVEL_MAX) ? lpc_pkg::LEVEL_MAX : level_pct;

    // an empty window takes the first sample in all three slots
    always_comb
    begin
        win_next[0] = filled_reg ? win_reg[1] : sample;
        win_next[1] = filled_reg ? win_reg[2] : sample;
        win_next[2] = sample;
    end

    // median of the window as it stands after the push
    always_comb
    begin
        lo     = (win_next[0] > win_next[1]) ? win_next[1] : win_next[0];
        hi     = (win_next[0] > win_next[1]) ? win_next[0] : win_next[1];
        hi_c   = (hi > win_next[2]) ? win_next[2] : hi;
        median = (lo > hi_c) ? lo : hi_c;
    end

    always_comb
    begin
        filled_next = filled_reg;
        if (clear)
        begin
            filled_next = 1'b0;
        end
        else if (push)
        begin
            filled_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filled_reg <= 1'b0;
        end
        else
        begin
            filled_reg <= filled_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            win_reg[0] <= win_next[0];
            win_reg[1] <= win_next[1];
            win_reg[2] <= win_next[2];
        end
    end

endmodule

@@ hdl/lpc_ctrl.sv @@
// lpc_ctrl: pump mode state machine with confirmation, failure and recovery counters
`timescale 1ns / 1ps

module lpc_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  lpc_pkg::lpc_in_t              item,
    input  logic [lpc_pkg::LEVEL_W-1:0]   median,
    input  lpc_pkg::lpc_cfg_t             cfg,
    output lpc_pkg::lpc_ctrl_t            ctrl
);

    lpc_pkg::mode_t              mode_reg;
    lpc_pkg::mode_t              mode_next;
    logic [lpc_pkg::COUNT_W-1:0] confirm_reg;
    logic [lpc_pkg::COUNT_W-1:0] confirm_next;
    logic [lpc_pkg::COUNT_W-1:0] fail_reg;
    logic [lpc_pkg::COUNT_W-1:0] fail_next;
    logic [lpc_pkg::COUNT_W-1:0] recov_reg;
    logic [lpc_pkg::COUNT_W-1:0] recov_next;
    logic [lpc_pkg::TIME_W-1:0]  start_time_reg;
    logic [lpc_pkg::TIME_W-1:0]  start_time_next;
    logic [lpc_pkg::COUNT_W-1:0] fail_inc;
    logic [lpc_pkg::COUNT_W-1:0] confirm_inc;
    logic [lpc_pkg::COUNT_W-1:0] recov_inc;
    logic [lpc_pkg::TIME_W-1:0]  elapsed;
    logic                        window_clear;

    assign fail_inc    = (fail_reg == lpc_pkg::COUNT_MAX) ? fail_reg : fail_reg + 1'b1;
    assign confirm_inc = confirm_reg + 1'b1;
    assign recov_inc   = recov_reg + 1'b1;
    assign elapsed     = item.now_ms - start_time_reg;

    always_comb
    begin
        mode_next       = mode_reg;
        confirm_next    = confirm_reg;
        fail_next       = fail_reg;
        recov_next      = recov_reg;
        start_time_next = start_time_reg;
        window_clear    = 1'b0;
        if (step)
        begin
            if (!item.reading_valid)
            begin
                recov_next   = '0;
                confirm_next = '0;
                fail_next    = fail_inc;
                if (fail_inc >= cfg.failure_limit &&
                    mode_reg != lpc_pkg::MODE_TIMEOUT &&
                    mode_reg != lpc_pkg::MODE_SENSOR)
                begin
                    mode_next    = lpc_pkg::MODE_SENSOR;
                    window_clear = 1'b1;
                end
            end
            else
            begin
                fail_next = '0;
                unique case (mode_reg)
                    lpc_pkg::MODE_SENSOR:
                    begin
                        recov_next = recov_inc;
                        if (recov_inc >= cfg.recovery_confirmations)
                        begin
                            mode_next    = lpc_pkg::MODE_OFF;
                            confirm_next = '0;
                            recov_next   = '0;
                        end
                    end
                    lpc_pkg::MODE_OFF:
                    begin
                        if (median <= cfg.start_threshold_pct)
                        begin
                            confirm_next = confirm_inc;
                            if (confirm_inc >= cfg.change_confirmations)
                            begin
                                mode_next       = lpc_pkg::MODE_RUN;
                                start_time_next = item.now_ms;
                                confirm_next    = '0;
                            end
                        end
                        else
                        begin
                            confirm_next = '0;
                        end
                    end
                    lpc_pkg::MODE_RUN:
                    begin
                        // fill timeout wins over the stop condition
                        if (elapsed > cfg.max_fill_ms)
                        begin
                            mode_next    = lpc_pkg::MODE_TIMEOUT;
                            confirm_next = '0;
                        end
                        else if (median >= cfg.stop_threshold_pct)
                        begin
                            confirm_next = confirm_inc;
                            if (confirm_inc >= cfg.change_confirmations)
                            begin
                                mode_next    = lpc_pkg::MODE_OFF;
                                confirm_next = '0;
                            end
                        end
                        else
                        begin
                            confirm_next = '0;
                        end
                    end
                    lpc_pkg::MODE_TIMEOUT:
                    begin
                        mode_next = lpc_pkg::MODE_TIMEOUT;
                    end
                    default:
                    begin
                        mode_next = mode_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= lpc_pkg::MODE_OFF;
            confirm_reg <= '0;
            fail_reg    <= '0;
            recov_reg   <= '0;
        end
        else
        begin
            mode_reg    <= mode_next;
            confirm_reg <= confirm_next;
            fail_reg    <= fail_next;
            recov_reg   <= recov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        start_time_reg <= start_time_next;
    end

    assign ctrl.mode         = mode_reg;
    assign ctrl.mode_next    = mode_next;
    assign ctrl.window_clear = window_clear;

endmodule

@@ hdl/level_pump_controller_unit.sv @@
// level_pump_controller_unit: top level of the tank level pump controller
//
// Readings enter on in_valid/in_ready with in_data (level, valid flag, ms time).
// Each accepted reading produces exactly one result on out_valid/out_ready:
// the pump mode after that reading and the relay drive (on only while running).
// Configuration registers are written on cfg_valid/cfg_ready, which is always
// ready; index 0..5 selects the register, other indexes are ignored. Write only
// while no reading is in flight.
// A reading first sits in the input register; when the result register can take
// it, the median filter and mode logic update the state and load the result
// register. A new reading can be taken every cycle unless the receiver stalls.
// If the receiver stalls, the result register holds its transfer and the input
// register still takes one more reading; in_ready drops only when both are full.
// Reset clears the mode to off, all counters, the median window fill flag and
// restores the register defaults. No clearing pass is needed.
`timescale 1ns / 1ps

module level_pump_controller_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  lpc_pkg::lpc_in_t                  in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output lpc_pkg::lpc_out_t                 out_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lpc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lpc_pkg::CFG_DATA_W-1:0]    cfg_data
);

    lpc_pkg::lpc_in_t            in_reg;
    logic                        in_valid_reg;
    logic                        in_valid_next;
    lpc_pkg::lpc_out_t           out_reg;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic                        advance;
    logic                        step;
    logic                        in_take;
    lpc_pkg::lpc_cfg_t           cfg;
    lpc_pkg::lpc_ctrl_t          ctrl;
    logic [lpc_pkg::LEVEL_W-1:0] median;

    assign cfg_ready = 1'b1;
    assign advance   = !out_valid_reg || out_ready;
    assign step      = in_valid_reg && advance;
    assign in_ready  = !in_valid_reg || advance;
    assign in_take   = in_valid && in_ready;

    lpc_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    lpc_median u_median (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (step && in_reg.reading_valid),
        .clear     (ctrl.window_clear),
        .level_pct (in_reg.level_pct),
        .median    (median)
    );

    lpc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (in_reg),
        .median (median),
        .cfg    (cfg),
        .ctrl   (ctrl)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        out_valid_next = advance ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_reg <= in_data;
        end
        if (step)
        begin
            out_reg.relay_on <= (ctrl.mode_next == lpc_pkg::MODE_RUN);
            out_reg.mode     <= ctrl.mode_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // relay drive agrees with the reported mode
    a_relay_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.relay_on == (out_data.mode == lpc_pkg::MODE_RUN)))
        else $error("relay drive disagrees with mode");

    // timeout fault stays latched until reset
    a_timeout_latch: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.mode == lpc_pkg::MODE_TIMEOUT |=> ctrl.mode == lpc_pkg::MODE_TIMEOUT)
        else $error("timeout fault released without reset");

    // a waiting reading is not dropped while the output stalls
    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_reg))
        else $error("stalled reading lost");

    // no new transfer when both stages are full and the output stalls
    a_full_block: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_valid_reg && !out_ready |-> !in_ready)
        else $error("input taken while pipeline full");

    // state changes only when a reading moves to the result register
    a_mode_step: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(ctrl.mode))
        else $error("mode changed without a reading");

endmodule
